@@ hw/rtl/rds_pkg.sv @@
// ----------------------------------------------------------------------------
// rds_pkg - shared types and constants of the RSSI diversity selector
// Item kinds, mode codes, register indexes, widths and the control states.
// ----------------------------------------------------------------------------
package rds_pkg;

  localparam int unsigned RawW   = 12;
  localparam int unsigned PctW   = 7;
  localparam int unsigned CountW = 16;
  localparam int unsigned ChanW  = 6;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  // (raw - min) * 100 needs 12 + 7 bits
  localparam int unsigned NumW = RawW + PctW;

  localparam logic [PctW-1:0]   PctFull  = PctW'(100);
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [KindW-1:0] {
    KindTick   = 2'd0,
    KindSample = 2'd1,
    KindRetune = 2'd2,
    KindNone   = 2'd3
  } kind_e;

  localparam logic [ModeW-1:0] ModeAuto   = 2'd0;
  localparam logic [ModeW-1:0] ModeForceA = 2'd1;
  localparam logic [ModeW-1:0] ModeForceB = 2'd2;

  localparam logic RxA = 1'b0;
  localparam logic RxB = 1'b1;

  localparam logic [CfgIdxW-1:0] RegAMin    = 4'd0;
  localparam logic [CfgIdxW-1:0] RegAMax    = 4'd1;
  localparam logic [CfgIdxW-1:0] RegBMin    = 4'd2;
  localparam logic [CfgIdxW-1:0] RegBMax    = 4'd3;
  localparam logic [CfgIdxW-1:0] RegMode    = 4'd4;
  localparam logic [CfgIdxW-1:0] RegMargin  = 4'd5;
  localparam logic [CfgIdxW-1:0] RegHold    = 4'd6;
  localparam logic [CfgIdxW-1:0] RegSettle  = 4'd7;

  typedef enum logic [2:0] {
    StIdle,
    StDivA,
    StDivB,
    StDecide,
    StEmit
  } state_e;

endpackage

@@ hw/rtl/rds_if.sv @@
// ----------------------------------------------------------------------------
// rds_in_if / rds_out_if - valid/ready channels of the diversity selector
// Input carries one event item, output one status item.
// ----------------------------------------------------------------------------
interface rds_in_if;
  import rds_pkg::*;

  logic            valid;
  logic            ready;
  logic [1:0]      kind;
  logic [RawW-1:0] rssi_a_raw;
  logic [RawW-1:0] rssi_b_raw;
  logic [5:0]      channel;

  modport source (output valid, kind, rssi_a_raw, rssi_b_raw, channel, input ready);
  modport sink   (input valid, kind, rssi_a_raw, rssi_b_raw, channel, output ready);
endinterface

interface rds_out_if;
  import rds_pkg::*;

  logic            valid;
  logic            ready;
  logic            active_receiver;
  logic [PctW-1:0] rssi_a_pct;
  logic [PctW-1:0] rssi_b_pct;
  logic            rssi_stable;
  logic [5:0]      active_channel;

  modport source (output valid, active_receiver, rssi_a_pct, rssi_b_pct, rssi_stable,
                  active_channel, input ready);
  modport sink   (input valid, active_receiver, rssi_a_pct, rssi_b_pct, rssi_stable,
                  active_channel, output ready);
endinterface

@@ hw/rtl/rds_scale.sv @@
// ----------------------------------------------------------------------------
// rds_scale - bit-serial RSSI percentage scaler
// Restoring divider, one quotient bit per cycle: (raw-min)*100/(max-min),
// clamped to 100, zero when raw <= min or max <= min.
// ----------------------------------------------------------------------------
module rds_scale
  import rds_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [RawW-1:0] raw_i,
  input  logic [RawW-1:0] lo_i,
  input  logic [RawW-1:0] hi_i,
  output logic            done_o,
  output logic [PctW-1:0] pct_o
);

  localparam int unsigned StepW = $clog2(NumW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [RawW-1:0]  rem_q, rem_d;
  logic [NumW-1:0]  num_q, num_d;
  logic [RawW-1:0]  den_q, den_d;
  logic             zero_q, zero_d;

  logic [RawW-1:0] diff;
  logic [NumW-1:0] num_init;
  logic [RawW:0]   rem_shift;
  logic            q_bit;
  logic            over;

  assign diff     = raw_i - lo_i;
  // times 100 = 64 + 32 + 4
  assign num_init = {1'b0, diff, 6'b0} + {2'b0, diff, 5'b0} + {5'b0, diff, 2'b0};

  assign rem_shift = {rem_q, num_q[NumW-1]};
  assign q_bit     = (rem_shift >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    zero_d = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      num_d  = num_init;
      den_d  = hi_i - lo_i;
      zero_d = (hi_i <= lo_i) || (raw_i <= lo_i);
    end else if (busy_q) begin
      rem_d = q_bit ? RawW'(rem_shift - {1'b0, den_q}) : rem_shift[RawW-1:0];
      num_d = {num_q[NumW-2:0], q_bit};
      step_d = step_q + 1'b1;
      if (step_q == StepW'(NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    den_q  <= den_d;
    zero_q <= zero_d;
  end

  assign over   = (num_q > NumW'(PctFull));
  assign done_o = done_q;
  assign pct_o  = zero_q ? '0 : (over ? PctFull : num_q[PctW-1:0]);

endmodule

@@ hw/rtl/rssi_diversity_selector.sv @@
// ----------------------------------------------------------------------------
// rssi_diversity_selector - two-receiver antenna diversity switch
// Scales RSSI samples, tracks settle/hold counters and picks receiver A or B.
// ----------------------------------------------------------------------------
// Every item gives one status item. Ticks, retunes, unused kinds and samples
// taken before settling go from accept through the emit state into the
// output register. A sample pair taken after settling goes through one
// shared bit-serial divider, A then B, then the decide and emit states to the
// output load; the emit state waits while the output register holds an item
// not yet taken. One item is in work at a time; a new item is accepted as soon
// as the status item has moved into the output register, even if not taken.
module rssi_diversity_selector
  import rds_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  rds_in_if.sink              in_i,
  rds_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // configuration
  logic [RawW-1:0]   a_min_q, a_max_q, b_min_q, b_max_q;
  logic [ModeW-1:0]  mode_q;
  logic [PctW-1:0]   margin_q;
  logic [CountW-1:0] hold_ticks_q, settle_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_min_q        <= '0;
      a_max_q        <= '1;
      b_min_q        <= '0;
      b_max_q        <= '1;
      mode_q         <= ModeAuto;
      margin_q       <= PctW'(2);
      hold_ticks_q   <= CountW'(5);
      settle_ticks_q <= CountW'(30);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegAMin:   a_min_q        <= cfg_data_i[RawW-1:0];
        RegAMax:   a_max_q        <= cfg_data_i[RawW-1:0];
        RegBMin:   b_min_q        <= cfg_data_i[RawW-1:0];
        RegBMax:   b_max_q        <= cfg_data_i[RawW-1:0];
        RegMode:   mode_q         <= cfg_data_i[ModeW-1:0];
        RegMargin: margin_q       <= cfg_data_i[PctW-1:0];
        RegHold:   hold_ticks_q   <= cfg_data_i[CountW-1:0];
        RegSettle: settle_ticks_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // selector state
  state_e            state_q, state_d;
  logic [PctW-1:0]   pct_a_q, pct_b_q;
  logic              sel_q, target_q;
  logic [ChanW-1:0]  chan_q;
  logic [CountW-1:0] settle_q, hold_q;
  logic [RawW-1:0]   raw_b_q;
  logic              out_valid_q;
  logic              out_sel_q, out_stable_q;
  logic [PctW-1:0]   out_pct_a_q, out_pct_b_q;
  logic [ChanW-1:0]  out_chan_q;

  logic            accept;
  logic            settled;
  logic            out_free;
  logic            div_start, div_done;
  logic [RawW-1:0] div_raw, div_lo, div_hi;
  logic [PctW-1:0] div_pct;
  kind_e           kind;

  logic [PctW:0]   diff;
  logic [PctW-1:0] mag;
  logic            best;
  logic            lead_ok;

  assign kind     = kind_e'(in_i.kind);
  assign accept   = in_i.valid && in_i.ready;
  assign settled  = (settle_q >= settle_ticks_q);
  assign out_free = !out_valid_q || out_o.ready;

  assign diff    = {1'b0, pct_a_q} - {1'b0, pct_b_q};
  assign mag     = diff[PctW] ? PctW'(-diff) : diff[PctW-1:0];
  assign best    = (diff == '0) ? sel_q : diff[PctW];
  assign lead_ok = (mag >= margin_q);

  // divider operand select: A while starting from idle, B once A is done
  assign div_raw = (state_q == StIdle) ? in_i.rssi_a_raw : raw_b_q;
  assign div_lo  = (state_q == StIdle) ? a_min_q : b_min_q;
  assign div_hi  = (state_q == StIdle) ? a_max_q : b_max_q;

  rds_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .raw_i   (div_raw),
    .lo_i    (div_lo),
    .hi_i    (div_hi),
    .done_o  (div_done),
    .pct_o   (div_pct)
  );

  always_comb begin
    state_d    = state_q;
    div_start  = 1'b0;
    in_i.ready = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (kind == KindSample && settled) begin
            div_start = 1'b1;
            state_d   = StDivA;
          end else begin
            state_d = StEmit;
          end
        end
      end
      StDivA: begin
        if (div_done) begin
          div_start = 1'b1;
          state_d   = StDivB;
        end
      end
      StDivB: begin
        if (div_done) begin
          state_d = StDecide;
        end
      end
      StDecide: state_d = StEmit;
      StEmit: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      pct_a_q  <= '0;
      pct_b_q  <= '0;
      sel_q    <= RxA;
      target_q <= RxA;
      chan_q   <= '0;
      settle_q <= '0;
      hold_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        unique case (kind)
          KindTick: begin
            if (settle_q != CountMax) settle_q <= settle_q + 1'b1;
            if (hold_q != CountMax)   hold_q   <= hold_q + 1'b1;
          end
          KindRetune: begin
            chan_q   <= in_i.channel;
            settle_q <= '0;
          end
          default: ;
        endcase
      end
      if (state_q == StDivA && div_done) pct_a_q <= div_pct;
      if (state_q == StDivB && div_done) pct_b_q <= div_pct;
      if (state_q == StDecide) begin
        unique case (mode_q)
          ModeAuto: begin
            if (lead_ok) begin
              if (best == target_q) begin
                if (hold_q >= hold_ticks_q) sel_q <= target_q;
              end else begin
                target_q <= best;
                hold_q   <= '0;
              end
            end else begin
              hold_q <= '0;
            end
          end
          ModeForceA: sel_q <= RxA;
          ModeForceB: sel_q <= RxB;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_b_q <= in_i.rssi_b_raw;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StEmit && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StEmit && out_free) begin
      out_sel_q    <= sel_q;
      out_pct_a_q  <= pct_a_q;
      out_pct_b_q  <= pct_b_q;
      out_stable_q <= settled;
      out_chan_q   <= chan_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.active_receiver = out_sel_q;
  assign out_o.rssi_a_pct      = out_pct_a_q;
  assign out_o.rssi_b_pct      = out_pct_b_q;
  assign out_o.rssi_stable     = out_stable_q;
  assign out_o.active_channel  = out_chan_q;

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb - testbench of the RSSI diversity selector
// Drives event items and register writes, keeps its own model of the
// selector, and checks every status item field by field while the source
// pauses in bursts and the sink stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rds_pkg::*;

  localparam logic [ModeW-1:0] ModeUnused = 2'd3;
  localparam int unsigned      StuckLimit = 2000;
  localparam int unsigned      RunCap     = 40;

  typedef struct packed {
    kind_e            kind;
    logic [RawW-1:0]  raw_a;
    logic [RawW-1:0]  raw_b;
    logic [ChanW-1:0] chan;
  } rx_event_t;

  typedef struct packed {
    logic             rx;
    logic [PctW-1:0]  pct_a;
    logic [PctW-1:0]  pct_b;
    logic             stable;
    logic [ChanW-1:0] chan;
  } rx_status_t;

  typedef struct packed {
    logic [RawW-1:0]   a_lo;
    logic [RawW-1:0]   a_hi;
    logic [RawW-1:0]   b_lo;
    logic [RawW-1:0]   b_hi;
    logic [ModeW-1:0]  mode;
    logic [PctW-1:0]   margin;
    logic [CountW-1:0] hold;
    logic [CountW-1:0] settle;
  } sel_cfg_t;

  class status_scoreboard;
    logic [RawW-1:0]   a_lo, a_hi, b_lo, b_hi;
    logic [ModeW-1:0]  mode;
    logic [PctW-1:0]   margin;
    logic [CountW-1:0] hold_lim, settle_lim;
    logic [PctW-1:0]   pct_a, pct_b;
    logic              sel_rx, tgt_rx;
    logic [ChanW-1:0]  chan;
    logic [CountW-1:0] settle_cnt, hold_cnt;
    rx_status_t        status_q[$];
    int unsigned       errors;

    function new();
      a_lo = '0;  a_hi = '1;  b_lo = '0;  b_hi = '1;
      mode = ModeAuto;
      margin = PctW'(2);
      hold_lim = CountW'(5);
      settle_lim = CountW'(30);
      pct_a = '0;  pct_b = '0;
      sel_rx = RxA;  tgt_rx = RxA;
      chan = '0;
      settle_cnt = '0;  hold_cnt = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegAMin:   a_lo = data[RawW-1:0];
        RegAMax:   a_hi = data[RawW-1:0];
        RegBMin:   b_lo = data[RawW-1:0];
        RegBMax:   b_hi = data[RawW-1:0];
        RegMode:   mode = data[ModeW-1:0];
        RegMargin: margin = data[PctW-1:0];
        RegHold:   hold_lim = data[CountW-1:0];
        RegSettle: settle_lim = data[CountW-1:0];
        default: ;
      endcase
    endfunction

    function logic [PctW-1:0] to_pct(logic [RawW-1:0] raw, logic [RawW-1:0] lo,
                                     logic [RawW-1:0] hi);
      int unsigned num, span, p;
      // empty or inverted calibration and raw at or below the floor read 0
      if (hi <= lo || raw <= lo) return '0;
      num = raw - lo;
      span = hi - lo;
      p = (num * PctFull) / span;
      return (p > PctFull) ? PctFull : PctW'(p);
    endfunction

    function logic [CountW-1:0] bump(logic [CountW-1:0] v);
      return (v == CountMax) ? v : v + 1'b1;
    endfunction

    function void pick_rx();
      int          d;
      int unsigned mag;
      logic        best;
      case (mode)
        ModeAuto: begin
          d = int'(pct_a) - int'(pct_b);
          mag = (d < 0) ? -d : d;
          best = (d > 0) ? RxA : ((d < 0) ? RxB : sel_rx);
          if (mag >= margin) begin
            if (best == tgt_rx) begin
              if (hold_cnt >= hold_lim) sel_rx = tgt_rx;
            end else begin
              tgt_rx = best;
              hold_cnt = '0;
            end
          end else begin
            hold_cnt = '0;
          end
        end
        ModeForceA: sel_rx = RxA;
        ModeForceB: sel_rx = RxB;
        default: ;
      endcase
    endfunction

    function void take_event(rx_event_t ev);
      case (ev.kind)
        KindTick: begin
          settle_cnt = bump(settle_cnt);
          hold_cnt = bump(hold_cnt);
        end
        KindSample: begin
          if (settle_cnt >= settle_lim) begin
            pct_a = to_pct(ev.raw_a, a_lo, a_hi);
            pct_b = to_pct(ev.raw_b, b_lo, b_hi);
            pick_rx();
          end
        end
        KindRetune: begin
          chan = ev.chan;
          settle_cnt = '0;
        end
        default: ;
      endcase
      status_q.push_back(rx_status_t'{sel_rx, pct_a, pct_b, settle_cnt >= settle_lim, chan});
    endfunction

    function void compare(string field, int unsigned want_v, int unsigned got_v);
      if (want_v != got_v) begin
        errors++;
        $display("%0t ns: %s expected %0d actual %0d", $time, field, want_v, got_v);
      end
    endfunction

    function void check_status(rx_status_t got);
      rx_status_t want;
      if (status_q.size() == 0) begin
        errors++;
        $display("%0t ns: status item with none pending (rx %0d a %0d b %0d ch %0d)",
                 $time, got.rx, got.pct_a, got.pct_b, got.chan);
        return;
      end
      want = status_q.pop_front();
      compare("active_receiver", want.rx, got.rx);
      compare("rssi_a_pct", want.pct_a, got.pct_a);
      compare("rssi_b_pct", want.pct_b, got.pct_b);
      compare("rssi_stable", want.stable, got.stable);
      compare("active_channel", want.chan, got.chan);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  rds_in_if  ev_if ();
  rds_out_if st_if ();

  rssi_diversity_selector DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (ev_if),
    .out_o      (st_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  status_scoreboard status_sb;
  sel_cfg_t    cur_cfg = '{12'd0, 12'd4095, 12'd0, 12'd4095, ModeAuto, 7'd2, 16'd5, 16'd30};
  int unsigned useful_items = 0;
  int unsigned burst_left = 0;
  int unsigned stuck_cycles = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  int unsigned pat_left = 0;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (ev_if.valid && ev_if.ready)
        status_sb.take_event(rx_event_t'{kind_e'(ev_if.kind), ev_if.rssi_a_raw,
                                         ev_if.rssi_b_raw, ev_if.channel});
      if (st_if.valid && st_if.ready)
        status_sb.check_status(rx_status_t'{st_if.active_receiver, st_if.rssi_a_pct,
                                            st_if.rssi_b_pct, st_if.rssi_stable,
                                            st_if.active_channel});
    end
  end

  // sink stalls: a 16-bit pattern rotates and is replaced when its random run length expires
  always @(posedge clk_i) begin
    if (pat_left == 0) begin
      pat_left <= $urandom_range(400, 50);
      case ($urandom_range(3))
        0: stall_pat <= '1;
        1: stall_pat <= 16'($urandom) | 16'h0001;
        2: stall_pat <= 16'h8888;
        default: stall_pat <= 16'($urandom) | 16'($urandom);
      endcase
    end else begin
      pat_left <= pat_left - 1;
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
    end
    st_if.ready <= stall_pat[15];
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (ev_if.valid && ev_if.ready) || (st_if.valid && st_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("tb: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // source pacing: bursts of random length, mostly followed by a gap
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(24, 1);
      if ($urandom_range(3) != 0) begin
        ev_if.valid <= 1'b0;
        repeat ($urandom_range(12, 1)) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_event(kind_e k, logic [RawW-1:0] ra, logic [RawW-1:0] rb,
                            logic [ChanW-1:0] ch);
    ev_if.valid      <= 1'b1;
    ev_if.kind       <= k;
    ev_if.rssi_a_raw <= ra;
    ev_if.rssi_b_raw <= rb;
    ev_if.channel    <= ch;
    do @(posedge clk_i); while (!ev_if.ready);
    if (k != KindNone) useful_items++;
    pace();
  endtask

  task automatic send_tick();
    send_event(KindTick, RawW'($urandom), RawW'($urandom), ChanW'($urandom));
  endtask

  // wait until every status item is back; the block is then idle
  task automatic drain();
    ev_if.valid <= 1'b0;
    do @(posedge clk_i); while (status_sb.status_q.size() != 0);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    status_sb.write_reg(idx, data);
  endtask

  function automatic logic [CfgDataW-1:0] pad(int unsigned v, int unsigned w, bit junk);
    logic [CfgDataW-1:0] hi_bits;
    hi_bits = junk ? (CfgDataW'($urandom) << w) : '0;
    return CfgDataW'(v) | hi_bits;
  endfunction

  task automatic load_config(sel_cfg_t c, bit junk);
    cfg_write(RegAMin,   pad(c.a_lo, RawW, junk));
    cfg_write(RegAMax,   pad(c.a_hi, RawW, junk));
    cfg_write(RegBMin,   pad(c.b_lo, RawW, junk));
    cfg_write(RegBMax,   pad(c.b_hi, RawW, junk));
    cfg_write(RegMode,   pad(c.mode, ModeW, junk));
    cfg_write(RegMargin, pad(c.margin, PctW, junk));
    cfg_write(RegHold,   pad(c.hold, CountW, junk));
    cfg_write(RegSettle, pad(c.settle, CountW, junk));
    // index past the last register must not disturb anything
    if (junk) cfg_write(CfgIdxW'(RegSettle + 1 + $urandom_range(7)), CfgDataW'($urandom));
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic sel_cfg_t random_cfg();
    sel_cfg_t c;
    c.a_lo = RawW'($urandom_range(2500));
    c.a_hi = ($urandom_range(7) == 0) ? RawW'($urandom)
                                      : RawW'(c.a_lo + 100 + $urandom_range(1495));
    c.b_lo = RawW'($urandom_range(2500));
    c.b_hi = ($urandom_range(7) == 0) ? RawW'($urandom)
                                      : RawW'(c.b_lo + 100 + $urandom_range(1495));
    c.mode   = ModeW'($urandom_range(3));
    c.margin = PctW'($urandom_range(127));
    c.hold   = CountW'($urandom_range(6));
    c.settle = CountW'($urandom_range(4));
    return c;
  endfunction

  function automatic logic [RawW-1:0] raw_for(int unsigned pct, logic [RawW-1:0] lo,
                                              logic [RawW-1:0] hi);
    int unsigned r;
    if (hi <= lo) return RawW'($urandom);
    r = lo + (pct * (hi - lo) + PctFull - 1) / PctFull;
    return (r >= (1 << RawW)) ? '1 : RawW'(r);
  endfunction

  task automatic send_pair(logic fav, int unsigned p_fav, int unsigned p_oth);
    int unsigned pa, pb;
    pa = (fav == RxA) ? p_fav : p_oth;
    pb = (fav == RxA) ? p_oth : p_fav;
    send_event(KindSample, raw_for(pa, cur_cfg.a_lo, cur_cfg.a_hi),
               raw_for(pb, cur_cfg.b_lo, cur_cfg.b_hi), ChanW'($urandom));
  endtask

  // one receiver leads by about the margin, ticks near hold_ticks in between
  task automatic lead_run();
    logic fav;
    int   lead, hi_p, reps, ticks;
    fav = 1'($urandom_range(1));
    reps = $urandom_range(3, 1);
    for (int r = 0; r < reps; r++) begin
      lead = int'(cur_cfg.margin) + int'($urandom_range(4)) - 2;
      if (lead < 0) lead = 0;
      if (lead > 100) lead = 100;
      hi_p = $urandom_range(100, lead);
      send_pair(fav, hi_p, hi_p - lead);
      if (r < reps - 1) begin
        ticks = int'(cur_cfg.hold) + int'($urandom_range(3)) - 1;
        if (ticks < 0) ticks = 0;
        if (ticks > RunCap) ticks = RunCap;
        repeat (ticks) send_tick();
      end
    end
  endtask

  task automatic settle_run();
    int ticks;
    send_event(KindRetune, RawW'($urandom), RawW'($urandom), ChanW'($urandom));
    ticks = int'(cur_cfg.settle) + int'($urandom_range(2)) - 1;
    if (ticks < 0) ticks = 0;
    if (ticks > RunCap) ticks = RunCap;
    repeat (ticks) send_tick();
    lead_run();
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(4, 1))
      send_event(kind_e'(KindW'($urandom_range(3))), RawW'($urandom), RawW'($urandom),
                 ChanW'($urandom));
  endtask

  task automatic run_phase(sel_cfg_t c, bit junk, int unsigned n);
    int unsigned stop_at, pick;
    drain();
    load_config(c, junk);
    stop_at = useful_items + n;
    while (useful_items < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) lead_run();
      else if (pick < 70) settle_run();
      else noise_burst();
    end
  endtask

  initial begin
    status_sb = new();
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_data         <= '0;
    ev_if.valid      <= 1'b0;
    ev_if.kind       <= KindTick;
    ev_if.rssi_a_raw <= '0;
    ev_if.rssi_b_raw <= '0;
    ev_if.channel    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: unused kind, sample before settling, retune extremes
    send_event(KindNone, '1, '1, '1);
    send_event(KindSample, '1, '1, '0);
    send_event(KindRetune, '0, '0, '1);
    send_event(KindTick, '0, '0, '0);
    send_event(KindRetune, '1, '1, '0);

    drain();
    load_config('{12'd100, 12'd3000, 12'd0, 12'd4095, ModeAuto, 7'd3, 16'd2, 16'd1}, 1'b0);
    send_event(KindTick, '0, '0, '0);
    send_event(KindSample, '0, '1, '0);         // A below floor, B full: target B
    send_event(KindTick, '0, '0, '0);
    send_event(KindTick, '0, '0, '0);
    send_event(KindSample, '0, '1, '0);         // lead held long enough: switch to B
    send_event(KindSample, '1, '0, '0);         // A above ceiling clamps
    send_event(KindSample, 12'd100, 12'd100, '0);
    send_event(KindTick, '0, '0, '0);
    send_event(KindTick, '0, '0, '0);
    send_event(KindSample, 12'd2990, 12'd4095, '0);
    send_event(KindSample, 12'd1550, 12'd2048, '0);  // equal percentages
    send_event(KindRetune, '0, '0, 6'd42);
    send_event(KindSample, '1, '0, '0);         // unsettled again: ignored
    send_event(KindNone, '0, '0, '0);

    run_phase('{12'd0, 12'd4095, 12'd0, 12'd4095, ModeAuto, 7'd2, 16'd3, 16'd2}, 1'b0, 60);
    run_phase('{12'd1000, 12'd3000, 12'd500, 12'd2500, ModeAuto, 7'd0, 16'd0, 16'd0},
              1'b0, 60);
    run_phase('{12'd200, 12'd1200, 12'd2000, 12'd2100, ModeAuto, 7'd100, 16'd1, 16'd1},
              1'b0, 60);
    run_phase('{12'd0, 12'd4095, 12'd4095, 12'd0, ModeForceA, 7'd10, 16'd2, 16'd1}, 1'b0, 60);
    run_phase('{12'd2048, 12'd2048, 12'd100, 12'd4000, ModeForceB, 7'd5, 16'd1, 16'd0},
              1'b0, 60);
    run_phase('{12'd300, 12'd3300, 12'd0, 12'd4095, ModeUnused, 7'd4, 16'd2, 16'd1}, 1'b0, 60);
    run_phase(random_cfg(), 1'b1, 60);
    run_phase('{12'd4095, 12'd4095, 12'd0, 12'd1, ModeAuto, 7'd1, 16'd2, 16'd3}, 1'b0, 60);
    run_phase(random_cfg(), 1'b1, 60);
    run_phase('{12'd0, 12'd4095, 12'd0, 12'd4095, ModeAuto, 7'd2, 16'd4, 16'd2}, 1'b0, 60);

    drain();
    repeat (60) @(posedge clk_i);
    if (status_sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/rds_pkg.sv
hw/rtl/rds_if.sv
hw/rtl/rds_scale.sv
hw/rtl/rssi_diversity_selector.sv
test/tb.sv
